/* rtl/mbs_pkg.sv */
// ----------------------------------------------------------------------------
// mbs_pkg: shared types and constants for the multiset bag store
// Operation and status codes, beat layouts and the per-cell control bundle.
// ----------------------------------------------------------------------------
package mbs_pkg;

	localparam int unsigned CAPACITY_DEF    = 64;
	localparam int unsigned VALUE_WIDTH_DEF = 32;

	localparam int unsigned OP_W     = 2;
	localparam int unsigned IN_VAL_W = 32;
	localparam int unsigned STATUS_W = 2;
	localparam int unsigned RES_W    = 7;

	localparam int unsigned S_TDATA_W = ((OP_W + IN_VAL_W + 7) / 8) * 8;
	localparam int unsigned M_TDATA_W = ((STATUS_W + 2 * RES_W + 7) / 8) * 8;

	typedef enum logic [OP_W-1:0] {
		OP_INSERT    = 2'd0,
		OP_ERASE_ONE = 2'd1,
		OP_ERASE_ALL = 2'd2,
		OP_COUNT     = 2'd3
	} op_t;

	typedef enum logic [STATUS_W-1:0] {
		ST_DONE     = 2'd0,
		ST_FULL     = 2'd1,
		ST_NO_MATCH = 2'd2
	} status_t;

	typedef struct packed {
		logic load;
		logic shift;
		logic clear;
		logic write;
	} cell_ctrl_t;

endpackage

/* rtl/mbs_cell.sv */
// ----------------------------------------------------------------------------
// mbs_cell: one slot of the bag store chain
// Holds one entry and its match flag; loads, compares, and shifts down from
// the next cell.
// ----------------------------------------------------------------------------
module mbs_cell #(
	parameter int unsigned VALUE_WIDTH = mbs_pkg::VALUE_WIDTH_DEF,
	parameter int unsigned CNT_W       = 7,
	parameter int unsigned INDEX       = 0
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  mbs_pkg::cell_ctrl_t    ctrl,
	input  logic [VALUE_WIDTH-1:0] key,
	input  logic [CNT_W-1:0]       fill,
	input  logic                   above,
	input  logic                   lowest,
	input  logic [VALUE_WIDTH-1:0] next_value,
	input  logic                   next_flag,
	output logic [VALUE_WIDTH-1:0] value,
	output logic                   flag
);
	import mbs_pkg::*;

	logic [VALUE_WIDTH-1:0] value_q;
	logic                   flag_q;
	logic                   occupied;
	logic                   at_tail;

	assign occupied = fill > CNT_W'(INDEX);
	assign at_tail  = fill == CNT_W'(INDEX);

	always_ff @(posedge clk) begin
		if (ctrl.write && at_tail) begin
			value_q <= key;
		end else if (ctrl.shift && above) begin
			value_q <= next_value;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			flag_q <= 1'b0;
		end else if (ctrl.load) begin
			flag_q <= occupied && (value_q == key);
		end else if (ctrl.shift && above) begin
			flag_q <= next_flag;
		end else if (ctrl.clear && lowest) begin
			flag_q <= 1'b0;
		end
	end

	assign value = value_q;
	assign flag  = flag_q;

endmodule

/* rtl/multiset_bag_store_core.sv */
// ----------------------------------------------------------------------------
// multiset_bag_store_core: fixed-capacity multiset kept in insertion order
// Insert, erase-first, erase-all and count over a chain of entry cells.
// ----------------------------------------------------------------------------
// Insert: the result beat is registered in S_EXEC once the output is free.
// Erase and count: S_EXEC loads the match flags, then S_STEP removes or
// counts one match per cycle (erase-one at most one), then registers the result.
// One item in flight; the next beat is taken the cycle after the result is
// registered. An untaken result beat holds the next result until it leaves.
// Reset clears occupancy, match flags and the output beat; entries undefined.
module multiset_bag_store_core #(
	parameter int unsigned CAPACITY    = mbs_pkg::CAPACITY_DEF,
	parameter int unsigned VALUE_WIDTH = mbs_pkg::VALUE_WIDTH_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          s_tvalid,
	output logic                          s_tready,
	input  logic [mbs_pkg::S_TDATA_W-1:0] s_tdata,  // operation, value, zero pad
	output logic                          m_tvalid,
	input  logic                          m_tready,
	output logic [mbs_pkg::M_TDATA_W-1:0] m_tdata   // status, matches_res, occupancy
);
	import mbs_pkg::*;

	localparam int unsigned CNT_W = $clog2(CAPACITY + 1);

	typedef enum logic [1:0] {
		S_IDLE,
		S_EXEC,
		S_STEP
	} state_t;

	state_t                 state_q;
	op_t                    op_q;
	logic [VALUE_WIDTH-1:0] key_q;
	logic [CNT_W-1:0]       fill_q;
	logic [CNT_W-1:0]       cnt_q;
	logic                   m_tvalid_q;
	logic [M_TDATA_W-1:0]   m_tdata_q;

	cell_ctrl_t             ctrl;
	logic [CAPACITY-1:0]    flag_v;
	logic [CAPACITY-1:0]    low_v;
	logic [CAPACITY-1:0]    above_v;
	logic [VALUE_WIDTH-1:0] value_v [CAPACITY];
	logic                   out_free;
	logic                   full;
	logic                   is_erase;
	logic                   more;
	logic                   accept;
	logic                   res_load;

	assign accept   = s_tvalid && (state_q == S_IDLE);
	assign out_free = !m_tvalid_q || m_tready;
	assign full     = fill_q >= CNT_W'(CAPACITY);
	assign is_erase = (op_q == OP_ERASE_ONE) || (op_q == OP_ERASE_ALL);
	assign more     = (|flag_v) && !((op_q == OP_ERASE_ONE) && (cnt_q != '0));
	assign res_load = out_free && (((state_q == S_EXEC) && (op_q == OP_INSERT)) ||
		((state_q == S_STEP) && !more));

	assign low_v   = flag_v & (~flag_v + CAPACITY'(1));
	assign above_v = ~(low_v - CAPACITY'(1));

	always_comb begin
		ctrl = '0;
		unique case (state_q)
			S_IDLE: ;
			S_EXEC: begin
				if (op_q == OP_INSERT) begin
					ctrl.write = out_free && !full;
				end else begin
					ctrl.load = 1'b1;
				end
			end
			S_STEP: begin
				ctrl.shift = more && is_erase;
				ctrl.clear = more && (op_q == OP_COUNT);
			end
			default: ;
		endcase
	end

	for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
		logic [VALUE_WIDTH-1:0] nv;
		logic                   nf;
		if (i == CAPACITY - 1) begin : g_end
			assign nv = value_v[i];
			assign nf = 1'b0;
		end else begin : g_mid
			assign nv = value_v[i+1];
			assign nf = flag_v[i+1];
		end
		mbs_cell #(
			.VALUE_WIDTH(VALUE_WIDTH),
			.CNT_W      (CNT_W),
			.INDEX      (i)
		) u_cell (
			.clk       (clk),
			.arst_n    (arst_n),
			.ctrl      (ctrl),
			.key       (key_q),
			.fill      (fill_q),
			.above     (above_v[i]),
			.lowest    (low_v[i]),
			.next_value(nv),
			.next_flag (nf),
			.value     (value_v[i]),
			.flag      (flag_v[i])
		);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= S_IDLE;
			op_q       <= OP_INSERT;
			key_q      <= '0;
			fill_q     <= '0;
			cnt_q      <= '0;
			m_tvalid_q <= 1'b0;
			m_tdata_q  <= '0;
		end else begin
			if (m_tvalid_q && m_tready && !res_load) begin
				m_tvalid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (accept) begin
						op_q    <= op_t'(s_tdata[OP_W-1:0]);
						key_q   <= VALUE_WIDTH'(s_tdata[OP_W +: IN_VAL_W]);
						cnt_q   <= '0;
						state_q <= S_EXEC;
					end
				end
				S_EXEC: begin
					if (op_q != OP_INSERT) begin
						state_q <= S_STEP;
					end else if (out_free) begin
						m_tvalid_q <= 1'b1;
						m_tdata_q  <= M_TDATA_W'({RES_W'(full ? fill_q : fill_q + 1'b1),
							RES_W'(0), full ? ST_FULL : ST_DONE});
						if (!full) begin
							fill_q <= fill_q + 1'b1;
						end
						state_q <= S_IDLE;
					end
				end
				S_STEP: begin
					if (more) begin
						cnt_q <= cnt_q + 1'b1;
						if (is_erase) begin
							fill_q <= fill_q - 1'b1;
						end
					end else if (out_free) begin
						m_tvalid_q <= 1'b1;
						m_tdata_q  <= M_TDATA_W'({RES_W'(fill_q), RES_W'(cnt_q),
							(is_erase && (cnt_q == '0)) ? ST_NO_MATCH : ST_DONE});
						state_q    <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign s_tready = (state_q == S_IDLE);
	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;

	a_fill_bound: assert property (@(posedge clk) disable iff (!arst_n)
		fill_q <= CNT_W'(CAPACITY))
		else $error("occupancy above capacity");

	a_count_keeps_fill: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_STEP && op_q == OP_COUNT) |=> (fill_q == $past(fill_q)))
		else $error("count changed occupancy");

	a_erase_one_single: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_STEP && op_q == OP_ERASE_ONE) |-> (cnt_q <= CNT_W'(1)))
		else $error("erase-one removed more than one entry");

	a_no_flags_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_STEP && !more && op_q == OP_ERASE_ALL) |-> (flag_v == '0))
		else $error("erase-all left a match behind");

endmodule
